/* src/ppsa_pkg.sv */
// shared types, constants and codes for the preemptive priority scheduler with aging
// no dependencies; imported by ppsa_cell and the top level
package ppsa_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int SLOT_W  = 4;
    localparam int PRIO_W  = 8;
    localparam int LEN_W   = 16;
    localparam int TIME_W  = 24;

    localparam logic [TIME_W-1:0] TIME_MAX     = '1;
    localparam logic [1:0]        AGE_LIMIT    = 2'd3;
    localparam logic [PRIO_W-1:0] MIN_PRIORITY = 8'd1;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SWEEP,
        S_APPLY,
        S_POST
    } t_state;

    typedef struct packed {
        t_cmd               command;
        logic [SLOT_W-1:0]  slot;
        logic [PRIO_W-1:0]  priority_in;
        logic [LEN_W-1:0]   burst_in;
        logic [LEN_W-1:0]   arrival_in;
    } t_in_item;

    typedef struct packed {
        logic               ran;
        logic [SLOT_W-1:0]  run_slot;
        logic               finished;
        logic [TIME_W-1:0]  completion_time;
        logic [TIME_W-1:0]  turnaround;
        logic [TIME_W-1:0]  waiting_time;
        logic               all_done;
    } t_out_item;

    // best candidate so far, handed from cell to cell
    typedef struct packed {
        logic               found;
        logic [1:0]         pend;      // pending entries seen, saturates at 2
        logic [IDX_W-1:0]   idx;
        logic [PRIO_W-1:0]  prio;
        logic [LEN_W-1:0]   arrival;
        logic [LEN_W-1:0]   burst;
        logic [LEN_W-1:0]   remaining;
    } t_cand;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic               load;
        logic               clear;
        logic               tick;
        logic [IDX_W-1:0]   load_idx;
        logic [PRIO_W-1:0]  prio;
        logic [LEN_W-1:0]   burst;
        logic [LEN_W-1:0]   arrival;
        logic               pick_found;
        logic [IDX_W-1:0]   pick_idx;
        logic [TIME_W-1:0]  now;
    } t_cell_ctrl;

endpackage

/* src/ppsa_cell.sv */
// one table entry of the scheduler chain: entry state plus one stage of the candidate search
// depends on ppsa_pkg
module ppsa_cell import ppsa_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_index,
    input  t_cell_ctrl       i_ctrl,
    input  t_cand            i_cand,
    output t_cand            o_cand
);

    logic              r_valid;
    logic              r_done;
    logic [PRIO_W-1:0] r_prio;
    logic [LEN_W-1:0]  r_arrival;
    logic [LEN_W-1:0]  r_burst;
    logic [LEN_W-1:0]  r_remaining;
    logic [1:0]        r_age;
    t_cand             r_cand;
    t_cand             n_cand;

    logic              w_pending;
    logic              w_ready;
    logic              w_better;
    logic              w_take;
    logic [1:0]        w_pend;
    logic              w_load_me;
    logic              w_pick_me;
    logic [1:0]        w_age_inc;

    always_comb begin
        w_pending = r_valid && !r_done;
        w_ready   = w_pending && ({{(TIME_W-LEN_W){1'b0}}, r_arrival} <= i_ctrl.now);
        w_better  = (r_prio < i_cand.prio) ||
                    ((r_prio == i_cand.prio) && (r_arrival < i_cand.arrival));
        w_take    = w_ready && (!i_cand.found || w_better);
        w_pend    = (i_cand.pend == 2'd2) ? 2'd2 : i_cand.pend + {1'b0, w_pending};
        n_cand    = i_cand;
        if (w_take) begin
            n_cand.found     = 1'b1;
            n_cand.idx       = i_index;
            n_cand.prio      = r_prio;
            n_cand.arrival   = r_arrival;
            n_cand.burst     = r_burst;
            n_cand.remaining = r_remaining;
        end
        n_cand.pend = w_pend;
        w_load_me = i_ctrl.load && (i_ctrl.load_idx == i_index);
        w_pick_me = i_ctrl.pick_found && (i_ctrl.pick_idx == i_index);
        w_age_inc = r_age + 2'd1;
    end

    always_ff @(posedge i_clk) begin
        r_cand <= n_cand;
    end

    assign o_cand = r_cand;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_done  <= 1'b0;
        end else if (i_ctrl.clear) begin
            r_valid <= 1'b0;
            r_done  <= 1'b0;
        end else if (w_load_me) begin
            r_valid <= 1'b1;
            r_done  <= (i_ctrl.burst == '0);
        end else if (i_ctrl.tick && w_pick_me && (r_remaining == 16'd1)) begin
            r_done  <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_me) begin
            r_prio      <= i_ctrl.prio;
            r_burst     <= i_ctrl.burst;
            r_remaining <= i_ctrl.burst;
            r_arrival   <= i_ctrl.arrival;
            r_age       <= 2'd0;
        end else if (i_ctrl.tick && i_ctrl.pick_found) begin
            if (w_pick_me) begin
                r_remaining <= r_remaining - 16'd1;
            end else if (w_ready) begin
                // aged entries wrap their counter; the priority number floors at one
                if (w_age_inc == AGE_LIMIT) begin
                    r_age <= 2'd0;
                    if (r_prio > MIN_PRIORITY) begin
                        r_prio <= r_prio - 8'd1;
                    end
                end else begin
                    r_age <= w_age_inc;
                end
            end
        end
    end

endmodule

/* src/preemptive_priority_scheduler_aging.sv */
// top level of the preemptive priority scheduler with aging: sequencer, time counter, cell chain
// depends on ppsa_pkg and ppsa_cell
//
// Every transfer on the input channel gives exactly one transfer on the output channel.
// A load writes one table slot, a tick runs the ready entry with the smallest priority
// number for one time unit and ages the other ready entries, a clear empties the table and zeroes time.
// Each command passes the sequencer states in order: the best candidate travels one cell per
// cycle down the chain of ENTRIES cells (S_SWEEP), S_APPLY updates all cells at once (after
// the sweep for a tick, before it for the other commands) and S_POST forms the result,
// holding it while the output register is still full. The input is ready again in the same
// cycle as the result is offered.
// A new command is taken once the previous one has left the sequencer, even while its
// result still waits in the output register.
module preemptive_priority_scheduler_aging import ppsa_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out
);

    // sequencer state
    t_state            r_state;
    t_state            n_state;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  n_cnt;
    t_in_item          r_item;
    logic [TIME_W-1:0] r_time;
    logic [TIME_W-1:0] n_time;

    // captured at the update cycle of every command; used only for a tick
    t_cand             r_pick;
    logic              r_fin;
    logic [TIME_W-1:0] r_tat;

    // output register
    t_out_item         r_out;
    t_out_item         n_out;
    logic              r_out_valid;
    logic              w_out_load;

    // chain wiring
    t_cand             w_cand [ENTRIES+1];
    t_cand             w_end;
    t_cell_ctrl        w_ctrl;

    logic                     w_accept;
    logic                     w_is_tick;
    logic                     w_slot_ok;
    logic [SLOT_W+IDX_W-1:0]  w_slot_ext;
    logic [SLOT_W+IDX_W-1:0]  w_idx_ext;
    logic [TIME_W-1:0]        w_time_inc;
    logic [TIME_W-1:0]        w_burst_ext;

    assign w_accept  = i_in_valid && o_in_ready;
    assign w_is_tick = (r_item.command == CMD_TICK);
    assign w_end     = w_cand[ENTRIES];

    // slot widened or narrowed to the table index; slots past the table are dropped
    assign w_slot_ext = {{IDX_W{1'b0}}, r_item.slot};
    assign w_slot_ok  = (32'(r_item.slot) < 32'(ENTRIES));
    assign w_idx_ext  = {{SLOT_W{1'b0}}, r_pick.idx};

    // saturating time step
    assign w_time_inc  = (r_time == TIME_MAX) ? r_time : r_time + 24'd1;
    assign w_burst_ext = {{(TIME_W-LEN_W){1'b0}}, r_pick.burst};

    // seed of the chain: nothing found, nothing pending
    always_comb begin
        w_cand[0] = '0;
    end

    for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
        ppsa_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (IDX_W'(k)),
            .i_ctrl  (w_ctrl),
            .i_cand  (w_cand[k]),
            .o_cand  (w_cand[k+1])
        );
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state, cell broadcast and result forming
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_time     = r_time;
        o_in_ready = 1'b0;
        w_out_load = 1'b0;

        w_ctrl            = '0;
        w_ctrl.now        = r_time;
        w_ctrl.load_idx   = w_slot_ext[IDX_W-1:0];
        w_ctrl.prio       = r_item.priority_in;
        w_ctrl.burst      = r_item.burst_in;
        w_ctrl.arrival    = r_item.arrival_in;
        w_ctrl.pick_idx   = w_end.idx;

        n_out = '0;

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                n_cnt      = '0;
                if (i_in_valid) begin
                    // a tick searches on the old table, other commands search after the update
                    n_state = (i_in.command == CMD_TICK) ? S_SWEEP : S_APPLY;
                end
            end
            S_SWEEP: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(ENTRIES - 1)) begin
                    n_state = w_is_tick ? S_APPLY : S_POST;
                end
            end
            S_APPLY: begin
                n_cnt = '0;
                case (r_item.command)
                    CMD_LOAD: begin
                        w_ctrl.load = w_slot_ok;
                    end
                    CMD_CLEAR: begin
                        w_ctrl.clear = 1'b1;
                        n_time       = '0;
                    end
                    CMD_TICK: begin
                        w_ctrl.tick       = 1'b1;
                        w_ctrl.pick_found = w_end.found;
                        n_time            = w_time_inc;
                    end
                    default: begin
                    end
                endcase
                n_state = w_is_tick ? S_POST : S_SWEEP;
            end
            S_POST: begin
                if (w_is_tick) begin
                    n_out.ran      = r_pick.found;
                    n_out.run_slot = r_pick.found ? w_idx_ext[SLOT_W-1:0] : '0;
                    n_out.finished = r_fin;
                    if (r_fin) begin
                        n_out.completion_time = r_time;
                        n_out.turnaround      = r_tat;
                        n_out.waiting_time    = (r_tat > w_burst_ext) ?
                                                r_tat - w_burst_ext : '0;
                    end
                    // pending count was taken before the update; the finished entry leaves it
                    n_out.all_done = (r_pick.pend == 2'd0) ||
                                     ((r_pick.pend == 2'd1) && r_fin);
                end else begin
                    n_out.all_done = (w_end.pend == 2'd0);
                end
                if (!r_out_valid || i_out_ready) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_time <= '0;
        end else begin
            r_cnt  <= n_cnt;
            r_time <= n_time;
        end
    end

    // command and tick payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_in;
        end
        if (r_state == S_APPLY) begin
            r_pick <= w_end;
            r_fin  <= w_is_tick && w_end.found && (w_end.remaining == 16'd1);
            r_tat  <= w_time_inc - {{(TIME_W-LEN_W){1'b0}}, w_end.arrival};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // a finished entry is always one that ran
    a_fin_ran: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.ran || !o_out.finished))
        else $error("finished reported without a run");

    // the sweep counter stays inside the chain length
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> (r_cnt < CNT_W'(ENTRIES)))
        else $error("sweep counter past the chain");

    // time moves only in the update cycle
    a_time_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_APPLY) |=> (r_time == $past(r_time)))
        else $error("time changed outside the update cycle");

    // a result appears only from the result cycle
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state != S_POST) && !o_out_valid) |=> !o_out_valid)
        else $error("result offered without being formed");

endmodule
